// ===== hdl/pwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsm_pkg
// Shared types and constants for the polyline wide-stroke miter expander.
// ----------------------------------------------------------------------------
package pwsm_pkg;

  localparam int COORD_W = 32;   // Q16.16 coordinate
  localparam int CFG_W   = 31;   // config register width
  localparam int MUL_W   = 34;   // shared multiplier operand width
  localparam int RAD_W   = 66;   // root radicand width
  localparam int ROOT_W  = 33;   // root result width
  localparam int DIV_N_W = 80;   // divider dividend width
  localparam int DIV_D_W = 64;   // divider divisor width
  localparam int DIV_Q_W = 32;   // kept quotient bits

  localparam logic [1:0] OP_CLOSE = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  localparam logic REG_STROKE_WIDTH = 1'b0;
  localparam logic REG_MITER_LIMIT  = 1'b1;

  localparam logic [CFG_W-1:0] STROKE_WIDTH_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MITER_LIMIT_RST  = 31'd1310720;

  // handshake status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/pwsm_mul.sv =====
// ----------------------------------------------------------------------------
// pwsm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pwsm_mul (
  input  logic                                clk,
  input  logic signed [pwsm_pkg::MUL_W-1:0]   op_a,
  input  logic signed [pwsm_pkg::MUL_W-1:0]   op_b,
  output logic signed [2*pwsm_pkg::MUL_W-1:0] prod
);
  import pwsm_pkg::*;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== hdl/pwsm_sqrt.sv =====
// ----------------------------------------------------------------------------
// pwsm_sqrt
// Bit-pair serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pwsm_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pwsm_pkg::RAD_W-1:0]    radicand,
  output logic [pwsm_pkg::ROOT_W-1:0]   root,
  output pwsm_pkg::unit_stat_t          stat
);
  import pwsm_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem2  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
      rad  <= '0;
      rem  <= '0;
      root <= '0;
    end else if (start) begin
      rad       <= radicand;
      rem       <= '0;
      root      <= '0;
      cnt       <= CNT_W'(ROOT_W);
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      rad  <= rad << 2;
      rem  <= fits ? rem2 - trial : rem2;
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

endmodule

// ===== hdl/pwsm_div.sv =====
// ----------------------------------------------------------------------------
// pwsm_div
// Restoring serial divider, one quotient bit per cycle; keeps the low
// quotient bits and flags any quotient at or above 2^(DIV_Q_W-1).
// ----------------------------------------------------------------------------
module pwsm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pwsm_pkg::DIV_N_W-1:0]  dividend,
  input  logic [pwsm_pkg::DIV_D_W-1:0]  divisor,
  output logic [pwsm_pkg::DIV_Q_W-1:0]  quot,
  output logic                          big,
  output pwsm_pkg::unit_stat_t          stat
);
  import pwsm_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W:0]   rem2;
  logic [CNT_W-1:0]   cnt;
  logic               ovf;
  logic               fits;

  assign rem2 = {rem[DIV_D_W-1:0], dvd[DIV_N_W-1]};
  assign fits = rem2 >= {1'b0, dsr};
  assign big  = ovf | quot[DIV_Q_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
      dvd  <= '0;
      dsr  <= '0;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      rem       <= '0;
      quot      <= '0;
      ovf       <= 1'b0;
      cnt       <= CNT_W'(DIV_N_W);
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      dvd  <= dvd << 1;
      rem  <= fits ? rem2 - {1'b0, dsr} : rem2;
      quot <= {quot[DIV_Q_W-2:0], fits};
      ovf  <= ovf | quot[DIV_Q_W-1];
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

endmodule

// ===== hdl/polyline_wide_stroke_miter.sv =====
// ----------------------------------------------------------------------------
// polyline_wide_stroke_miter
// Expands move/line/close path commands into Q16.16 stroke triangles.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the sequencer
// is idle. Before its first vertex, a drawn segment takes four multiplies on
// the shared multiplier, a square root and two serial divisions for the
// offset. Each join adds six multiplies, one division for the miter factor
// unless its denominator is zero, and two more multiplies when a miter is
// used. Vertices leave through an output register, one per cycle while
// m_tready is high; a command yields up to 20 vertices. Vertex coordinates
// saturate to 32 bits. tuser carries the primitive kind (0 strip, 1 separate
// triangles) and a primitive start flag; tlast marks the final vertex of the
// request.
// ----------------------------------------------------------------------------
module polyline_wide_stroke_miter (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,   // 0 stroke_width, 1 miter_limit
  input  logic [30:0] cfg_data,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,     // [1:0] operation, [33:2] point_x, [65:34] point_y
  // vertex stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // [31:0] vertex_x, [63:32] vertex_y
  output logic [1:0]  m_tuser,     // [0] primitive_kind, [1] primitive_start
  output logic        m_tlast      // last_of_run
);
  import pwsm_pkg::*;

  typedef enum logic [4:0] {
    IDLE, SEG_M0, SEG_M1, SEG_M2, SEG_M3, SEG_M4, SEG_RT, SEG_DX, SEG_DXW,
    SEG_DYW, SEG_EMIT, LOAD_J2, J_M0, J_M1, J_M2, J_M3, J_M4, J_M5, J_M6,
    J_CHK, J_DIV, J_SA, J_SB, J_SC, J_EMIT, FINISH
  } state_t;

  state_t st;

  // config
  logic [CFG_W-1:0] stroke_width, miter_limit;

  // path state
  logic signed [31:0] cur_x, cur_y, start_x, start_y;
  logic               drawn;
  logic signed [31:0] prev_x, prev_y, prev_px, prev_py;
  logic signed [31:0] first_x, first_y, first_px, first_py;

  // command in flight
  logic [1:0]         op;
  logic               do_join1, do_join2, in_j2;
  logic signed [31:0] sx1, sy1, sx2, sy2;
  logic [65:0]        acc;
  logic [65:0]        sumsq;
  logic [63:0]        ndx, ndy;
  logic [32:0]        len;
  logic [31:0]        pxm;
  logic signed [31:0] npx, npy;

  // join operands and results
  logic signed [31:0] jx, jy, jc, jd, ja, jb;
  logic signed [63:0] num, den;
  logic [30:0]        tm;
  logic               neg, miter;
  logic [45:0]        tbm, tam;
  logic [2:0]         idx;

  // input fields
  logic [1:0]         in_op;
  logic signed [31:0] in_x, in_y;
  assign in_op = s_tdata[1:0];
  assign in_x  = s_tdata[33:2];
  assign in_y  = s_tdata[65:34];

  assign cfg_ready = 1'b1;
  assign s_tready  = (st == IDLE);

  // segment direction
  logic signed [32:0] tx, ty;
  logic [32:0]        ax, ay;
  assign tx = {sx2[31], sx2} - {sx1[31], sx1};
  assign ty = {sy2[31], sy2} - {sy1[31], sy1};
  assign ax = tx[32] ? 33'(-tx) : 33'(tx);
  assign ay = ty[32] ? 33'(-ty) : 33'(ty);

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [31:0]               absa, absb;
  assign absa = ja[31] ? 32'(-ja) : 32'(ja);
  assign absb = jb[31] ? 32'(-jb) : 32'(jb);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      SEG_M0: begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
      SEG_M1: begin mul_a = {1'b0, ay}; mul_b = {1'b0, ay}; end
      SEG_M2: begin mul_a = {1'b0, ay}; mul_b = {3'b0, stroke_width}; end
      SEG_M3: begin mul_a = {1'b0, ax}; mul_b = {3'b0, stroke_width}; end
      J_M0:   begin mul_a = MUL_W'(jc); mul_b = MUL_W'(jc); end
      J_M1:   begin mul_a = MUL_W'(jd); mul_b = MUL_W'(jd); end
      J_M2:   begin mul_a = MUL_W'(jc); mul_b = MUL_W'(ja); end
      J_M3:   begin mul_a = MUL_W'(jd); mul_b = MUL_W'(jb); end
      J_M4:   begin mul_a = MUL_W'(ja); mul_b = MUL_W'(jd); end
      J_M5:   begin mul_a = MUL_W'(jb); mul_b = MUL_W'(jc); end
      J_SA:   begin mul_a = {3'b0, tm}; mul_b = {2'b0, absb}; end
      J_SB:   begin mul_a = {3'b0, tm}; mul_b = {2'b0, absa}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pwsm_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  // product rounded back to Q16.16, halves away from zero
  logic [61:0] psum;
  assign psum = prod[61:0] + 62'd32768;

  // square root
  logic             sqrt_start;
  logic [ROOT_W-1:0] sqrt_root;
  unit_stat_t       sqrt_stat;
  assign sqrt_start = (st == SEG_M3);

  pwsm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sumsq),
    .root(sqrt_root), .stat(sqrt_stat)
  );

  // divider
  logic                div_start;
  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]  div_d;
  logic [DIV_Q_W-1:0]  div_q;
  logic                div_big;
  unit_stat_t          div_stat;
  logic [63:0]         absnum, absden;
  logic                miter_ok;

  assign absnum = num[63] ? 64'(-num) : 64'(num);
  assign absden = den[63] ? 64'(-den) : 64'(den);
  assign div_start = (st == SEG_DX) || (st == SEG_DXW && div_stat.done) ||
                     (st == J_CHK && den != 64'sd0);
  assign miter_ok = !div_big && (div_q[30:0] < miter_limit);

  always_comb begin
    div_n = '0;
    div_d = {30'b0, len, 1'b0};
    case (st)
      SEG_DX:  div_n = DIV_N_W'({1'b0, ndx} + {32'b0, len});
      SEG_DXW: div_n = DIV_N_W'({1'b0, ndy} + {32'b0, len});
      J_CHK: begin
        div_n = {absnum, 16'b0};
        div_d = absden;
      end
      default: div_n = '0;
    endcase
  end

  pwsm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .quot(div_q), .big(div_big), .stat(div_stat)
  );

  // vertex generation
  logic signed [47:0] tb_s, ta_s;
  logic signed [31:0] base_x, base_y;
  logic signed [48:0] off_x, off_y;
  logic               sg, v_kind, v_start, v_end;
  logic signed [49:0] ex, ey;
  logic               emit_go, last_flag;

  assign tb_s = (neg ^ jb[31]) ? -{2'b0, tbm} : {2'b0, tbm};
  assign ta_s = (neg ^ ja[31]) ? -{2'b0, tam} : {2'b0, tam};

  always_comb begin
    base_x  = jx;
    base_y  = jy;
    off_x   = '0;
    off_y   = '0;
    sg      = 1'b0;
    v_kind  = 1'b0;
    v_start = 1'b0;
    v_end   = 1'b0;
    if (st == SEG_EMIT) begin
      base_x  = idx[1] ? sx2 : sx1;
      base_y  = idx[1] ? sy2 : sy1;
      off_x   = 49'(npx);
      off_y   = 49'(npy);
      sg      = idx[0];
      v_start = (idx == 3'd0);
      v_end   = (idx == 3'd3);
    end else if (miter) begin
      sg      = idx[2];
      v_start = (idx[1:0] == 2'd0);
      v_end   = (idx == 3'd7);
      case (idx[1:0])
        2'd0: begin
          off_x = 49'(ja) - 49'(tb_s);
          off_y = 49'(jb) + 49'(ta_s);
        end
        2'd1: begin off_x = 49'(ja); off_y = 49'(jb); end
        2'd2: begin off_x = 49'(jc); off_y = 49'(jd); end
        default: begin off_x = '0; off_y = '0; end
      endcase
    end else begin
      // bevel: two separate triangles
      v_kind  = 1'b1;
      v_start = (idx == 3'd0);
      v_end   = (idx == 3'd5);
      sg      = (idx >= 3'd3);
      case (idx)
        3'd0, 3'd3: begin off_x = 49'(ja); off_y = 49'(jb); end
        3'd1, 3'd4: begin off_x = 49'(jc); off_y = 49'(jd); end
        default:    begin off_x = '0; off_y = '0; end
      endcase
    end
  end

  assign ex = 50'(base_x) + (sg ? -50'(off_x) : 50'(off_x));
  assign ey = 50'(base_y) + (sg ? -50'(off_y) : 50'(off_y));

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic hi_same;
    hi_same = (v[49:31] == {19{v[49]}});
    if (hi_same) return v[31:0];
    return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  assign emit_go   = (st == SEG_EMIT || st == J_EMIT) && (!m_tvalid || m_tready);
  assign last_flag = v_end && ((st == SEG_EMIT) ? !(do_join1 || do_join2)
                                                 : (in_j2 || !do_join2));

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= IDLE;
      stroke_width <= STROKE_WIDTH_RST;
      miter_limit  <= MITER_LIMIT_RST;
      cur_x <= '0;  cur_y <= '0;  start_x <= '0;  start_y <= '0;
      drawn <= 1'b0;
      prev_x <= '0;  prev_y <= '0;  prev_px <= '0;  prev_py <= '0;
      first_x <= '0; first_y <= '0; first_px <= '0; first_py <= '0;
      op <= OP_MOVE;
      do_join1 <= 1'b0;
      do_join2 <= 1'b0;
      in_j2    <= 1'b0;
      idx      <= '0;
      miter    <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= '0;
      m_tlast  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STROKE_WIDTH: stroke_width <= cfg_data;
          REG_MITER_LIMIT:  miter_limit  <= cfg_data;
          default: ;
        endcase
      end

      // output register
      if (emit_go) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {sat32(ey), sat32(ex)};
        m_tuser  <= {v_start, v_kind};
        m_tlast  <= last_flag;
        idx      <= idx + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (st)
        IDLE: begin
          if (s_tvalid) begin
            op <= in_op;
            case (in_op)
              OP_MOVE: begin
                cur_x <= in_x;  cur_y <= in_y;
                start_x <= in_x; start_y <= in_y;
                drawn <= 1'b0;
              end
              OP_LINE: begin
                if (in_x != cur_x || in_y != cur_y) begin
                  sx1 <= cur_x; sy1 <= cur_y; sx2 <= in_x; sy2 <= in_y;
                  do_join1 <= drawn;
                  do_join2 <= 1'b0;
                  st <= SEG_M0;
                end
              end
              OP_CLOSE: begin
                if (cur_x != start_x || cur_y != start_y) begin
                  sx1 <= cur_x; sy1 <= cur_y; sx2 <= start_x; sy2 <= start_y;
                  do_join1 <= drawn;
                  do_join2 <= drawn;
                  st <= SEG_M0;
                end else if (drawn) begin
                  do_join1 <= 1'b0;
                  do_join2 <= 1'b1;
                  st <= LOAD_J2;
                end else begin
                  drawn <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        SEG_M0: st <= SEG_M1;
        SEG_M1: begin acc <= prod[65:0]; st <= SEG_M2; end
        SEG_M2: begin sumsq <= acc + prod[65:0]; st <= SEG_M3; end
        SEG_M3: begin ndx <= prod[63:0]; st <= SEG_M4; end
        SEG_M4: begin ndy <= prod[63:0]; st <= SEG_RT; end
        SEG_RT: begin
          if (sqrt_stat.done) begin
            len <= sqrt_root;
            st  <= SEG_DX;
          end
        end
        SEG_DX: st <= SEG_DXW;
        SEG_DXW: begin
          if (div_stat.done) begin
            pxm <= div_q;
            st  <= SEG_DYW;
          end
        end
        SEG_DYW: begin
          if (div_stat.done) begin
            npx <= (!ty[32] && ty != 33'sd0) ? -$signed(pxm) : $signed(pxm);
            npy <= tx[32] ? -$signed(div_q) : $signed(div_q);
            idx <= '0;
            st  <= SEG_EMIT;
          end
        end
        SEG_EMIT: begin
          if (emit_go && v_end) begin
            // join against the old trailing end, then the new segment
            // becomes the trailing end
            jx <= prev_x; jy <= prev_y; jc <= prev_px; jd <= prev_py;
            ja <= npx;    jb <= npy;
            prev_x <= sx2; prev_y <= sy2; prev_px <= npx; prev_py <= npy;
            if (!drawn) begin
              first_x <= sx1; first_y <= sy1; first_px <= npx; first_py <= npy;
            end
            in_j2 <= 1'b0;
            if (do_join1)      st <= J_M0;
            else if (do_join2) st <= LOAD_J2;
            else               st <= FINISH;
          end
        end
        LOAD_J2: begin
          jx <= prev_x; jy <= prev_y; jc <= prev_px; jd <= prev_py;
          ja <= first_px; jb <= first_py;
          in_j2 <= 1'b1;
          st <= J_M0;
        end
        J_M0: st <= J_M1;
        J_M1: begin num <= prod[63:0]; st <= J_M2; end
        J_M2: begin num <= num + prod[63:0]; st <= J_M3; end
        J_M3: begin num <= num - prod[63:0]; st <= J_M4; end
        J_M4: begin num <= num - prod[63:0]; st <= J_M5; end
        J_M5: begin den <= prod[63:0]; st <= J_M6; end
        J_M6: begin den <= den - prod[63:0]; st <= J_CHK; end
        J_CHK: begin
          idx <= '0;
          if (den != 64'sd0) begin
            st <= J_DIV;
          end else begin
            miter <= 1'b0;
            st    <= J_EMIT;
          end
        end
        J_DIV: begin
          if (div_stat.done) begin
            tm    <= div_q[30:0];
            neg   <= num[63] ^ den[63];
            miter <= miter_ok;
            st    <= miter_ok ? J_SA : J_EMIT;
          end
        end
        J_SA: st <= J_SB;
        J_SB: begin tbm <= psum[61:16]; st <= J_SC; end
        J_SC: begin tam <= psum[61:16]; st <= J_EMIT; end
        J_EMIT: begin
          if (emit_go && v_end) begin
            st <= (!in_j2 && do_join2) ? LOAD_J2 : FINISH;
          end
        end
        FINISH: begin
          if (op == OP_LINE) begin
            cur_x <= sx2; cur_y <= sy2;
            drawn <= 1'b1;
          end else begin
            cur_x <= start_x; cur_y <= start_y;
            drawn <= 1'b0;
          end
          st <= IDLE;
        end
        default: st <= IDLE;
      endcase
    end
  end

  // units are only restarted once idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_stat.busy) else $error("root restarted while busy");

  // the final vertex of a request always closes the command
  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    (emit_go && last_flag) |=> (st == FINISH)) else $error("tlast without finish");

endmodule

// ===== bench/polyline_wide_stroke_miter_test.sv =====
// ----------------------------------------------------------------------------
// polyline_wide_stroke_miter_test
// Drives path commands into the stroke expander under several settings of
// width and miter limit, predicts every emitted vertex and checks each one
// field by field in order, with random idling on both streams.
// ----------------------------------------------------------------------------
module polyline_wide_stroke_miter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pwsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  // operation code with no meaning; the block ignores it
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic kind;
    logic start;
    logic last;
  } vertex_t;

  // one end of a drawn segment: point and its perpendicular offset
  typedef struct {
    longint x, y, px, py;
  } seg_end_t;

  // directed request row; want_* is used only when check_first is set
  typedef struct {
    logic [1:0] op;
    int px, py;
    bit check_first;
    int want_x, want_y;
  } cmd_row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [30:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [71:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;

  polyline_wide_stroke_miter uut (.*);

  // stroke state mirrored for prediction
  longint unsigned width_q, limit_q;
  int cur_x, cur_y, sub_x, sub_y;
  bit drawn;
  seg_end_t prev_end, first_seg;

  vertex_t vertex_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void push_vertex(longint x, longint y, bit kind, bit start);
    vertex_t v;
    v.x = sat32(x);
    v.y = sat32(y);
    v.kind = kind;
    v.start = start;
    v.last = 0;
    vertex_queue.push_back(v);
  endfunction

  // floor square root of a 66-bit radicand, bit by bit
  function automatic longint unsigned isqrt66(logic [65:0] rad);
    logic [67:0] rem, trial;
    logic [33:0] root;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | rad[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // strip for one segment; returns its start and end records
  task automatic emit_segment(int x1, int y1, int x2, int y2,
                              output seg_end_t head, output seg_end_t tail);
    longint tx, ty, px, py;
    longint unsigned ax, ay, len;
    logic [65:0] rad;
    logic [127:0] nx, ny;
    tx = longint'(x2) - x1;
    ty = longint'(y2) - y1;
    ax = mag(tx);
    ay = mag(ty);
    rad = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    len = isqrt66(rad);
    if (len == 0) len = 1;
    nx = (128'(ay) * width_q + len) / (128'(len) * 2);
    ny = (128'(ax) * width_q + len) / (128'(len) * 2);
    px = ty > 0 ? -longint'(nx) : longint'(nx);
    py = tx < 0 ? -longint'(ny) : longint'(ny);
    push_vertex(x1 + px, y1 + py, 0, 1);
    push_vertex(x1 - px, y1 - py, 0, 0);
    push_vertex(x2 + px, y2 + py, 0, 0);
    push_vertex(x2 - px, y2 - py, 0, 0);
    head = '{x1, y1, px, py};
    tail = '{x2, y2, px, py};
  endtask

  function automatic longint scale_q16(longint unsigned tm, bit neg, longint v);
    logic [127:0] m;
    longint r;
    m = 128'(tm) * mag(v);
    r = longint'((m + 32768) >> 16);
    return (neg != (v < 0)) ? -r : r;
  endfunction

  // miter or bevel between the end p and the next segment's start q
  task automatic emit_join(seg_end_t p, seg_end_t q);
    longint x, y, c, d, a, b, num, den, ta, tb;
    longint unsigned un, ud, qi, r, f, tm;
    bit miter, neg;
    x = p.x; y = p.y; c = p.px; d = p.py; a = q.px; b = q.py;
    num = c*c + d*d - c*a - d*b;
    den = a*d - b*c;
    miter = 0; neg = 0; tm = 0;
    if (den != 0) begin
      un = mag(num);
      ud = mag(den);
      qi = un / ud;
      r = un % ud;
      f = 0;
      if (qi < 32768) begin
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          f = f << 1;
          if (r >= ud) begin
            r -= ud;
            f |= 1;
          end
        end
        tm = (qi << 16) | f;
        if (tm < limit_q) miter = 1;
      end
      neg = (num < 0) != (den < 0);
    end
    if (miter) begin
      tb = scale_q16(tm, neg, b);
      ta = scale_q16(tm, neg, a);
      push_vertex(x + a - tb, y + b + ta, 0, 1);
      push_vertex(x + a, y + b, 0, 0);
      push_vertex(x + c, y + d, 0, 0);
      push_vertex(x, y, 0, 0);
      push_vertex(x - a + tb, y - b - ta, 0, 1);
      push_vertex(x - a, y - b, 0, 0);
      push_vertex(x - c, y - d, 0, 0);
      push_vertex(x, y, 0, 0);
    end else begin
      push_vertex(x + a, y + b, 1, 1);
      push_vertex(x + c, y + d, 1, 0);
      push_vertex(x, y, 1, 0);
      push_vertex(x - a, y - b, 1, 0);
      push_vertex(x - c, y - d, 1, 0);
      push_vertex(x, y, 1, 0);
    end
  endtask

  task automatic stroke_to(int tx, int ty);
    seg_end_t head, tail;
    emit_segment(cur_x, cur_y, tx, ty, head, tail);
    if (drawn) emit_join(prev_end, head);
    else first_seg = head;
    prev_end = tail;
  endtask

  // advance the stroke state by one command and queue its vertices
  task automatic predict_command(logic [1:0] op, int px, int py);
    int queued;
    queued = vertex_queue.size();
    case (op)
      OP_MOVE: begin
        cur_x = px; cur_y = py; sub_x = px; sub_y = py;
        drawn = 0;
      end
      OP_LINE: begin
        if (px != cur_x || py != cur_y) begin
          stroke_to(px, py);
          drawn = 1;
          cur_x = px;
          cur_y = py;
        end
      end
      OP_CLOSE: begin
        if (cur_x != sub_x || cur_y != sub_y) stroke_to(sub_x, sub_y);
        if (drawn) emit_join(prev_end, first_seg);
        cur_x = sub_x; cur_y = sub_y;
        drawn = 0;
      end
      default: ;
    endcase
    if (vertex_queue.size() > queued) vertex_queue[$].last = 1;
  endtask

  // ---------------------------------------------------------------------------
  // Vertex checker: compares every accepted vertex against the oldest one
  // queued, and counts cycles with no handshake on any channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (vertex_queue.size() == 0) begin
          $display("%0t: unexpected vertex x=%h y=%h user=%b last=%b", $time,
                   m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
          errors++;
        end else begin
          want = vertex_queue.pop_front();
          if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y ||
              m_tuser[0] !== want.kind || m_tuser[1] !== want.start ||
              m_tlast !== want.last) begin
            $display("%0t: vertex mismatch expected x=%h y=%h kind=%b start=%b last=%b",
                     $time, want.x, want.y, want.kind, want.start, want.last);
            $display("%0t:                 actual   x=%h y=%h kind=%b start=%b last=%b",
                     $time, m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1],
                     m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [30:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == REG_STROKE_WIDTH) width_q = value;
    else limit_q = value;
  endtask

  // send one request; tvalid stays up for a following request and is
  // dropped by the idle loop or by drain
  task automatic send_command(logic [1:0] op, int px, int py);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tdata <= {6'd0, py, px, op};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    predict_command(op, px, py);
  endtask

  // wait for all vertices, then let a command without output finish
  task automatic drain();
    s_tvalid <= 0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord(int span);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return int'($urandom_range(2 * span)) - span;
    endcase
  endfunction

  // random polylines with some noise and unknown commands
  task automatic random_paths(int n, int span);
    int k, last_x, last_y, sides;
    k = 0;
    while (k < n) begin
      send_command(OP_MOVE, rand_coord(span), rand_coord(span));
      k++;
      sides = $urandom_range(5, 1);
      for (int s = 0; s < sides; s++) begin
        if ($urandom_range(9) == 0) begin
          send_command(OP_LINE, cur_x, cur_y);  // zero length
        end else begin
          last_x = rand_coord(span);
          last_y = rand_coord(span);
          send_command(OP_LINE, last_x, last_y);
        end
        k++;
      end
      case ($urandom_range(5))
        0: ;
        1: send_command(OP_RESERVED, $urandom, $urandom);
        default: send_command(OP_CLOSE, $urandom, $urandom);
      endcase
      k++;
      if ($urandom_range(4) == 0) begin
        send_command(OP_CLOSE, $urandom, $urandom);
        k++;
      end
    end
  endtask

  cmd_row_t directed[] = '{
    // after reset: line from origin, first vertex offset by half width
    '{OP_LINE, 32'h0001_0000, 0, 1, 0, 32'h0000_8000},
    '{OP_LINE, 32'h0001_0000, 32'h0001_0000, 0, 0, 0},
    '{OP_LINE, 32'h0001_0000, 32'h0001_0000, 0, 0, 0},  // zero length
    '{OP_CLOSE, 0, 0, 0, 0, 0},
    '{OP_CLOSE, 0, 0, 0, 0, 0},                         // nothing drawn
    '{OP_RESERVED, 32'h1234_5678, 32'h0bad_cafe, 0, 0, 0},  // unknown op
    '{OP_MOVE, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0},
    '{OP_LINE, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},  // longest segment
    '{OP_LINE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0},
    '{OP_LINE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
    '{OP_CLOSE, 0, 0, 0, 0, 0},
    '{OP_MOVE, 0, 0, 0, 0, 0},
    '{OP_LINE, 32'h0010_0000, 0, 1, 0, 32'h0000_8000},
    '{OP_LINE, 32'h0010_0001, 32'h0000_0001, 0, 0, 0},  // near-collinear
    '{OP_LINE, 0, 32'h0000_0001, 0, 0, 0},              // reversal
    '{OP_LINE, 32'h0000_0001, 32'h0010_0000, 0, 0, 0},
    '{OP_CLOSE, 0, 0, 0, 0, 0},
    '{OP_MOVE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
    '{OP_LINE, 32'h8000_0001, 32'h7fff_fffe, 0, 0, 0},  // one-step segment
    '{OP_MOVE, 32'h0005_0000, 32'hfffb_0000, 0, 0, 0}
  };

  initial begin
    vertex_t head;
    rst = 1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    s_tvalid = 0; s_tdata = 0;
    width_q = STROKE_WIDTH_RST;
    limit_q = MITER_LIMIT_RST;
    cur_x = 0; cur_y = 0; sub_x = 0; sub_y = 0; drawn = 0;
    prev_end = '{0, 0, 0, 0};
    first_seg = prev_end;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part at reset settings, no idling
    foreach (directed[i]) begin
      send_command(directed[i].op, directed[i].px, directed[i].py);
      if (directed[i].check_first) begin
        head = vertex_queue[$ - 3];
        if (head.x !== directed[i].want_x || head.y !== directed[i].want_y) begin
          $display("%0t: row %0d predicted first vertex %h,%h expected %h,%h", $time,
                   i, head.x, head.y, directed[i].want_x, directed[i].want_y);
          errors++;
        end
      end
    end
    // sender holds off until the block has emptied
    drain();

    // extreme settings: zero width forces bevels, full width, tiny limit
    write_reg(REG_STROKE_WIDTH, 31'd0);
    write_reg(REG_MITER_LIMIT, 31'h7fff_ffff);
    random_paths(15, 32'h0100_0000);
    drain();
    write_reg(REG_STROKE_WIDTH, 31'h7fff_ffff);
    write_reg(REG_MITER_LIMIT, 31'd0);
    random_paths(15, 32'h4000_0000);
    drain();

    // random phases with different idling
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 48 : 18) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 48 : 18) : 0;
      write_reg(REG_STROKE_WIDTH, 31'($urandom_range(1) ? $urandom
                                                        : $urandom_range(32'h0008_0000)));
      write_reg(REG_MITER_LIMIT, 31'($urandom_range(32'h0030_0000)));
      random_paths(55, $urandom_range(1) ? 32'h0100_0000 : 32'h7fff_ffff);
      drain();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/pwsm_pkg.sv
hdl/pwsm_mul.sv
hdl/pwsm_sqrt.sv
hdl/pwsm_div.sv
hdl/polyline_wide_stroke_miter.sv
bench/polyline_wide_stroke_miter_test.sv
